// ----- hdl/rgbsl_pkg.sv -----
// ============================================================================
// rgbsl_pkg: shared types and constants of the rgb status light
// Item layouts, command codes, register indexes, reset colours and the
// command/status bundles between controller and datapath.
// ============================================================================
package rgbsl_pkg;

    localparam int NUM_LEDS_DEF = 6;
    localparam int MAX_LEDS     = 8;

    // command codes of an input item
    localparam logic [2:0] CMD_TICK    = 3'd0;
    localparam logic [2:0] CMD_SET_ALL = 3'd1;
    localparam logic [2:0] CMD_SET_ONE = 3'd2;
    localparam logic [2:0] CMD_BLINK   = 3'd3;
    localparam logic [2:0] CMD_PING    = 3'd4;

    // result kinds
    localparam logic KIND_WORD   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [7:0] SEL_ALL   = 8'd255;
    localparam logic [7:0] MASK_ALL  = 8'hff;
    localparam logic [7:0] DIM_LEVEL = 8'h05;

    // configuration register indexes (address bit 2)
    localparam logic REG_BLINK_PERIOD    = 1'b0;
    localparam logic REG_STANDBY_TIMEOUT = 1'b1;

    localparam logic [7:0] BLINK_PERIOD_RST    = 8'd5;
    localparam logic [7:0] STANDBY_TIMEOUT_RST = 8'd0;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] led_select;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } in_item_t;

    typedef struct packed {
        logic       kind;
        logic [2:0] led_number;
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       status_nok;
        logic       last;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic load_item;
        logic adv_tick;
        logic do_toggle;
        logic set_dark;
        logic wake;
        logic act;
        logic emit_word;
        logic emit_status;
        logic word_last;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic in_tick;
        logic item_tick;
        logic toggle_due;
        logic standby_due;
        logic lit;
        logic frame_needed;
        logic at_last_word;
        logic out_free;
    } dp_stat_t;

    // {red, green, blue} after reset: leds 2 and 3 dim white, the rest dim red
    function automatic logic [23:0] reset_colour(input int idx);
        logic [23:0] c;
        if ((idx % MAX_LEDS) == 2 || (idx % MAX_LEDS) == 3) begin
            c = {DIM_LEVEL, DIM_LEVEL, DIM_LEVEL};
        end else begin
            c = {DIM_LEVEL, 8'd0, 8'd0};
        end
        return c;
    endfunction

endpackage

// ----- hdl/rgb_status_light_blink_watchdog_top.sv -----
// sequence: an item is taken in ST_IDLE; a tick then passes ST_ADV and ST_TDEC,
//   a command ST_WAKE and ST_ACT; a frame is NUM_LEDS words, a status one word
// flow: one item at a time, s_ready only in ST_IDLE; a command on a dark light sends a
//   wake frame, then any frame of its own, then a status word; words wait on m_ready
// reset: synchronous, active low; all but item_reg/m_data_reg return to defaults at once
// ============================================================================
// rgb_status_light_blink_watchdog_top: rgb status light with blink and standby
// APB register block for blink period and standby timeout, plus the
// sequencing controller and the light datapath.
// ============================================================================
module rgb_status_light_blink_watchdog_top #(
    parameter int NUM_LEDS = rgbsl_pkg::NUM_LEDS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  rgbsl_pkg::in_item_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output rgbsl_pkg::out_item_t m_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    logic [7:0] blink_period_reg, blink_period_next;
    logic [7:0] standby_timeout_reg, standby_timeout_next;
    logic       reg_write;

    rgbsl_pkg::dp_cmd_t  cmd;
    rgbsl_pkg::dp_stat_t stat;

    assign pready    = 1'b1;
    assign reg_write = psel && penable && pwrite;

    always_comb begin
        blink_period_next    = blink_period_reg;
        standby_timeout_next = standby_timeout_reg;
        if (reg_write) begin
            case (paddr[2])
                rgbsl_pkg::REG_BLINK_PERIOD:    blink_period_next    = pwdata[7:0];
                rgbsl_pkg::REG_STANDBY_TIMEOUT: standby_timeout_next = pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            rgbsl_pkg::REG_BLINK_PERIOD:    prdata = {24'd0, blink_period_reg};
            rgbsl_pkg::REG_STANDBY_TIMEOUT: prdata = {24'd0, standby_timeout_reg};
            default:                        prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blink_period_reg    <= rgbsl_pkg::BLINK_PERIOD_RST;
            standby_timeout_reg <= rgbsl_pkg::STANDBY_TIMEOUT_RST;
        end else begin
            blink_period_reg    <= blink_period_next;
            standby_timeout_reg <= standby_timeout_next;
        end
    end

    rgbsl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    rgbsl_datapath #(
        .NUM_LEDS (NUM_LEDS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_data          (s_data),
        .blink_period    (blink_period_reg),
        .standby_timeout (standby_timeout_reg),
        .cmd             (cmd),
        .stat            (stat),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data)
    );

endmodule

// ----- hdl/rgbsl_ctrl.sv -----
// ============================================================================
// rgbsl_ctrl: sequencing state machine of the rgb status light
// Walks one item through tick handling or command wake/action, then drives
// the frame and status words into the output register.
// ============================================================================
module rgbsl_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  rgbsl_pkg::dp_stat_t stat,
    output rgbsl_pkg::dp_cmd_t  cmd
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_ADV    = 7'b0000010,
        ST_TDEC   = 7'b0000100,
        ST_WAKE   = 7'b0001000,
        ST_ACT    = 7'b0010000,
        ST_FRAME  = 7'b0100000,
        ST_STATUS = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   stby_pend_reg, stby_pend_next;
    logic   act_pend_reg, act_pend_next;

    always_comb begin
        state_next     = state_reg;
        stby_pend_next = stby_pend_reg;
        act_pend_next  = act_pend_reg;
        cmd            = '0;
        s_ready        = (state_reg == ST_IDLE);
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_item  = 1'b1;
                    stby_pend_next = 1'b0;
                    act_pend_next  = 1'b0;
                    state_next     = stat.in_tick ? ST_ADV : ST_WAKE;
                end
            end
            ST_ADV: begin
                cmd.adv_tick = 1'b1;
                state_next   = ST_TDEC;
            end
            ST_TDEC: begin
                cmd.do_toggle = stat.toggle_due;
                if (stat.toggle_due) begin
                    stby_pend_next = stat.standby_due;
                    state_next     = ST_FRAME;
                end else if (stat.standby_due) begin
                    cmd.set_dark = 1'b1;
                    state_next   = ST_FRAME;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_WAKE: begin
                cmd.wake = 1'b1;
                if (!stat.lit) begin
                    // wake frame goes out before the action
                    act_pend_next = 1'b1;
                    state_next    = ST_FRAME;
                end else begin
                    state_next = ST_ACT;
                end
            end
            ST_ACT: begin
                cmd.act       = 1'b1;
                act_pend_next = 1'b0;
                state_next    = stat.frame_needed ? ST_FRAME : ST_STATUS;
            end
            ST_FRAME: begin
                cmd.word_last = stat.item_tick && !stby_pend_reg && stat.at_last_word;
                if (stat.out_free) begin
                    cmd.emit_word = 1'b1;
                    if (stat.at_last_word) begin
                        if (stby_pend_reg) begin
                            // standby frame right after the blink frame
                            cmd.set_dark   = 1'b1;
                            stby_pend_next = 1'b0;
                        end else if (act_pend_reg) begin
                            state_next = ST_ACT;
                        end else if (!stat.item_tick) begin
                            state_next = ST_STATUS;
                        end else begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            ST_STATUS: begin
                if (stat.out_free) begin
                    cmd.emit_status = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            stby_pend_reg <= 1'b0;
            act_pend_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            stby_pend_reg <= stby_pend_next;
            act_pend_reg  <= act_pend_next;
        end
    end

endmodule

// ----- hdl/rgbsl_datapath.sv -----
// ============================================================================
// rgbsl_datapath: state and output path of the rgb status light
// Holds the colour store, blink mask and phase, tick time, watchdog deadline,
// the current item and the output register; acts on controller commands.
// ============================================================================
module rgbsl_datapath #(
    parameter int NUM_LEDS = rgbsl_pkg::NUM_LEDS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  rgbsl_pkg::in_item_t s_data,
    input  logic [7:0]          blink_period,
    input  logic [7:0]          standby_timeout,
    input  rgbsl_pkg::dp_cmd_t  cmd,
    output rgbsl_pkg::dp_stat_t stat,
    output logic                m_valid,
    input  logic                m_ready,
    output rgbsl_pkg::out_item_t m_data
);

    localparam int CNT_W = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
    localparam logic [CNT_W-1:0] LAST_LED = CNT_W'(NUM_LEDS - 1);

    rgbsl_pkg::in_item_t  item_reg;
    logic [15:0]          tick_time_reg, tick_time_next;
    logic [15:0]          next_toggle_reg, next_toggle_next;
    logic [15:0]          deadline_reg, deadline_next;
    logic                 phase_reg, phase_next;
    logic                 lit_reg, lit_next;
    logic [7:0]           mask_reg, mask_next;
    logic [23:0]          colour_reg [NUM_LEDS];
    logic [23:0]          colour_next [NUM_LEDS];
    logic [CNT_W-1:0]     led_cnt_reg, led_cnt_next;
    logic                 m_valid_reg, m_valid_next;
    rgbsl_pkg::out_item_t m_data_reg, m_data_next;

    logic [15:0]      toggle_dist;
    logic             sel_ok;
    logic [CNT_W-1:0] sel_idx;
    logic [2:0]       led_idx;
    logic [23:0]      shown;
    logic             dark;
    logic             out_free;
    logic [23:0]      rgb_in;

    assign toggle_dist = next_toggle_reg - tick_time_reg;
    assign sel_ok      = item_reg.led_select < 8'(NUM_LEDS);
    assign sel_idx     = item_reg.led_select[CNT_W-1:0];
    assign led_idx     = 3'(led_cnt_reg);
    assign shown       = colour_reg[led_cnt_reg];
    assign dark        = !lit_reg || (!phase_reg && mask_reg[led_idx]);
    assign out_free    = !m_valid_reg || m_ready;
    assign rgb_in      = {item_reg.red_in, item_reg.green_in, item_reg.blue_in};

    always_comb begin
        stat.in_tick      = (s_data.cmd == rgbsl_pkg::CMD_TICK);
        stat.item_tick    = (item_reg.cmd == rgbsl_pkg::CMD_TICK);
        stat.toggle_due   = (toggle_dist[15:8] != 8'd0) || (toggle_dist == 16'd0);
        stat.standby_due  = (standby_timeout != 8'd0) && (deadline_reg == tick_time_reg);
        stat.lit          = lit_reg;
        stat.frame_needed = (item_reg.cmd == rgbsl_pkg::CMD_SET_ALL) ||
                            ((item_reg.cmd == rgbsl_pkg::CMD_SET_ONE) && sel_ok);
        stat.at_last_word = (led_cnt_reg == LAST_LED);
        stat.out_free     = out_free;
    end

    always_comb begin
        tick_time_next   = tick_time_reg;
        next_toggle_next = next_toggle_reg;
        deadline_next    = deadline_reg;
        phase_next       = phase_reg;
        lit_next         = lit_reg;
        mask_next        = mask_reg;
        for (int i = 0; i < NUM_LEDS; i++) begin
            colour_next[i] = colour_reg[i];
        end

        if (cmd.adv_tick) begin
            tick_time_next = tick_time_reg + 16'd1;
        end
        if (cmd.do_toggle) begin
            next_toggle_next = tick_time_reg + {8'd0, blink_period};
            phase_next       = !phase_reg;
        end
        if (cmd.wake) begin
            deadline_next = tick_time_reg + {8'd0, standby_timeout};
            lit_next      = 1'b1;
        end
        if (cmd.set_dark) begin
            lit_next = 1'b0;
        end
        if (cmd.act) begin
            case (item_reg.cmd)
                rgbsl_pkg::CMD_SET_ALL: begin
                    for (int i = 0; i < NUM_LEDS; i++) begin
                        colour_next[i] = rgb_in;
                    end
                    mask_next = 8'd0;
                end
                rgbsl_pkg::CMD_SET_ONE: begin
                    if (sel_ok) begin
                        for (int i = 0; i < NUM_LEDS; i++) begin
                            if (sel_idx == CNT_W'(i)) begin
                                colour_next[i] = rgb_in;
                            end
                        end
                        mask_next[item_reg.led_select[2:0]] = 1'b0;
                    end
                end
                rgbsl_pkg::CMD_BLINK: begin
                    if (item_reg.led_select == rgbsl_pkg::SEL_ALL) begin
                        mask_next = rgbsl_pkg::MASK_ALL;
                    end else if (item_reg.led_select < 8'(rgbsl_pkg::MAX_LEDS)) begin
                        mask_next[item_reg.led_select[2:0]] = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // frame word counter and output register
    always_comb begin
        led_cnt_next = led_cnt_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.emit_word) begin
            led_cnt_next = (led_cnt_reg == LAST_LED) ? '0 : led_cnt_reg + CNT_W'(1);
            m_valid_next = 1'b1;
            m_data_next.kind       = rgbsl_pkg::KIND_WORD;
            m_data_next.led_number = led_idx;
            m_data_next.red_out    = dark ? 8'd0 : shown[23:16];
            m_data_next.green_out  = dark ? 8'd0 : shown[15:8];
            m_data_next.blue_out   = dark ? 8'd0 : shown[7:0];
            m_data_next.status_nok = 1'b0;
            m_data_next.last       = cmd.word_last;
        end else if (cmd.emit_status) begin
            m_valid_next = 1'b1;
            m_data_next.kind       = rgbsl_pkg::KIND_STATUS;
            m_data_next.led_number = 3'd0;
            m_data_next.red_out    = 8'd0;
            m_data_next.green_out  = 8'd0;
            m_data_next.blue_out   = 8'd0;
            m_data_next.status_nok = ((item_reg.cmd == rgbsl_pkg::CMD_SET_ONE) && !sel_ok) ||
                                     (item_reg.cmd > rgbsl_pkg::CMD_PING);
            m_data_next.last       = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            item_reg <= s_data;
        end
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_time_reg   <= 16'd0;
            next_toggle_reg <= 16'd0;
            deadline_reg    <= 16'd0;
            phase_reg       <= 1'b1;
            lit_reg         <= 1'b1;
            mask_reg        <= 8'd0;
            led_cnt_reg     <= '0;
            m_valid_reg     <= 1'b0;
            for (int i = 0; i < NUM_LEDS; i++) begin
                colour_reg[i] <= rgbsl_pkg::reset_colour(i);
            end
        end else begin
            tick_time_reg   <= tick_time_next;
            next_toggle_reg <= next_toggle_next;
            deadline_reg    <= deadline_next;
            phase_reg       <= phase_next;
            lit_reg         <= lit_next;
            mask_reg        <= mask_next;
            led_cnt_reg     <= led_cnt_next;
            m_valid_reg     <= m_valid_next;
            for (int i = 0; i < NUM_LEDS; i++) begin
                colour_reg[i] <= colour_next[i];
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_emit_into_free_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_word || cmd.emit_status) |-> out_free)
        else $error("result loaded while output register is stalled");

    a_standby_only_on_command: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(lit_reg) |-> $past(cmd.set_dark))
        else $error("light went dark without a standby command");

    a_led_count_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        led_cnt_reg <= LAST_LED)
        else $error("frame word counter out of range");

    a_tick_time_only_on_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && !$past(cmd.adv_tick)) |-> $stable(tick_time_reg))
        else $error("tick time moved without a tick");

endmodule
